// ----- design/vru_pkg.sv -----
// Shared constants, codes and types for the vector rotation unit.
`default_nettype none
package vru_pkg;

  localparam int CordicStepsDef = 16;
  localparam int FracBitsDef    = 16;

  localparam int AngFrac  = 30;
  localparam int TableLen = 24;
  localparam int ZW       = 35;  // angle accumulator, Q.30
  localparam int XW       = 33;  // CORDIC x/y, Q2.30 plus headroom
  localparam int CW       = 36;  // dot product, cross terms, lane sine operand
  localparam int TW       = 38;  // rounded a*d term

  localparam logic signed [ZW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [ZW-1:0] TwoPiQ30  = 35'sd6746518852;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [XW-1:0] GainQ30   = 33'sd652032874;

  localparam logic [1:0] OpRotX    = 2'd0;
  localparam logic [1:0] OpRotY    = 2'd1;
  localparam logic [1:0] OpRotZ    = 2'd2;
  localparam logic [1:0] OpRotAxis = 2'd3;

  typedef struct packed {
    logic pass;  // component passes through unchanged
  } lane_ctl_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int idx);
    logic signed [ZW-1:0] r;
    case (idx)
      0:  r = 35'sd843314857;
      1:  r = 35'sd497837829;
      2:  r = 35'sd263043837;
      3:  r = 35'sd133525159;
      4:  r = 35'sd67021687;
      5:  r = 35'sd33543516;
      6:  r = 35'sd16775851;
      7:  r = 35'sd8388437;
      8:  r = 35'sd4194283;
      9:  r = 35'sd2097149;
      10: r = 35'sd1048576;
      11: r = 35'sd524288;
      12: r = 35'sd262144;
      13: r = 35'sd131072;
      14: r = 35'sd65536;
      15: r = 35'sd32768;
      16: r = 35'sd16384;
      17: r = 35'sd8192;
      18: r = 35'sd4096;
      19: r = 35'sd2048;
      20: r = 35'sd1024;
      21: r = 35'sd512;
      22: r = 35'sd256;
      23: r = 35'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/vector_rotation_unit.sv -----
// Top level: operand pipeline, CORDIC, three component lanes and output merge.
// Rotates a Q16.16 vector about x, y, z or a given Q1.16 axis (Rodrigues) by a
// Q4.16 angle. Fully pipelined: one transaction accepted per clock while the
// output is not stalled. The CORDIC pipeline (one stage per iteration plus
// reduction and rounding) is followed by two lane stages and the output
// register. The whole pipeline advances whenever the output register is empty
// or being taken, so in_ready follows out_ready. Saturated lets the user see
// that at least one rotated component was clipped to the 32-bit range.
`default_nettype none
module vector_rotation_unit
  import vru_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int FRAC_BITS    = FracBitsDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_op,
  input  wire logic signed [31:0] in_vx,
  input  wire logic signed [31:0] in_vy,
  input  wire logic signed [31:0] in_vz,
  input  wire logic signed [17:0] in_ax,
  input  wire logic signed [17:0] in_ay,
  input  wire logic signed [17:0] in_az,
  input  wire logic signed [19:0] in_angle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_rx,
  output logic signed [31:0]      out_ry,
  output logic signed [31:0]      out_rz,
  output logic                    out_saturated
);

  localparam int P = CORDIC_STEPS + 2;

  logic en;
  logic [P+2:1] vld_r;
  logic out_valid_r;

  logic [1:0]         op_d [1:P];
  logic signed [31:0] v_d  [1:P][3];
  logic signed [17:0] a_d  [1:2][3];
  logic signed [49:0] av_r [3][3];   // av_r[j][k] = a_j * v_k
  logic signed [CW-1:0] d_r;
  logic signed [CW-1:0] cr_d [2:P][3];
  logic signed [53:0] ad_r [3];
  logic signed [TW-1:0] t_d [4:P][3];

  logic signed [51:0] dot, crs [3];
  logic signed [51:0] dsh, csh [3];
  logic signed [53:0] tsh [3];

  logic signed [FRAC_BITS+2:0] cos_w, sin_w;

  lane_ctl_t          ctl  [3];
  logic signed [TW-1:0] p1 [3];
  logic signed [CW-1:0] p3 [3];
  logic signed [31:0] res [3];
  logic               sat [3];

  logic signed [31:0] rx_r, ry_r, rz_r;
  logic               sat_r;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[P+1:1], in_valid};
      out_valid_r <= vld_r[P+2];
    end
  end

  vru_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk   (clk),
    .en    (en),
    .angle (in_angle),
    .cos_o (cos_w),
    .sin_o (sin_w)
  );

  // depth 1: the nine axis products
  always_ff @(posedge clk) begin
    if (en) begin
      av_r[0][0] <= in_ax * in_vx;
      av_r[0][1] <= in_ax * in_vy;
      av_r[0][2] <= in_ax * in_vz;
      av_r[1][0] <= in_ay * in_vx;
      av_r[1][1] <= in_ay * in_vy;
      av_r[1][2] <= in_ay * in_vz;
      av_r[2][0] <= in_az * in_vx;
      av_r[2][1] <= in_az * in_vy;
      av_r[2][2] <= in_az * in_vz;
    end
  end

  // operand capture and delay lines
  always_ff @(posedge clk) begin
    if (en) begin
      op_d[1]   <= in_op;
      v_d[1][0] <= in_vx;
      v_d[1][1] <= in_vy;
      v_d[1][2] <= in_vz;
      a_d[1][0] <= in_ax;
      a_d[1][1] <= in_ay;
      a_d[1][2] <= in_az;
      for (int i = 2; i <= P; i++) begin
        op_d[i] <= op_d[i-1];
        for (int k = 0; k < 3; k++) v_d[i][k] <= v_d[i-1][k];
      end
      for (int k = 0; k < 3; k++) a_d[2][k] <= a_d[1][k];
    end
  end

  // depth 2: dot product and cross terms, rounded to Q16
  always_comb begin
    dot    = 52'(av_r[0][0]) + 52'(av_r[1][1]) + 52'(av_r[2][2]);
    crs[0] = 52'(av_r[1][2]) - 52'(av_r[2][1]);
    crs[1] = 52'(av_r[2][0]) - 52'(av_r[0][2]);
    crs[2] = 52'(av_r[0][1]) - 52'(av_r[1][0]);
    dsh    = (dot + 52'sd32768) >>> 16;
    for (int k = 0; k < 3; k++) csh[k] = (crs[k] + 52'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= dsh[CW-1:0];
      for (int k = 0; k < 3; k++) cr_d[2][k] <= csh[k][CW-1:0];
      for (int i = 3; i <= P; i++)
        for (int k = 0; k < 3; k++) cr_d[i][k] <= cr_d[i-1][k];
    end
  end

  // depth 3 and 4: a_i * d, rounded
  always_comb begin
    for (int k = 0; k < 3; k++) tsh[k] = (ad_r[k] + 54'sd32768) >>> 16;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ad_r[k]   <= a_d[2][k] * d_r;
        t_d[4][k] <= tsh[k][TW-1:0];
      end
      for (int i = 5; i <= P; i++)
        for (int k = 0; k < 3; k++) t_d[i][k] <= t_d[i-1][k];
    end
  end

  // lane operand select: r = p1*(1-c) + v*c + p3*s
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ctl[k].pass = 1'b0;
      p1[k] = '0;
      p3[k] = '0;
    end
    case (op_d[P])
      OpRotX: begin
        ctl[0].pass = 1'b1;
        p3[1] = CW'(v_d[P][2]);
        p3[2] = -CW'(v_d[P][1]);
      end
      OpRotY: begin
        ctl[1].pass = 1'b1;
        p3[0] = -CW'(v_d[P][2]);
        p3[2] = CW'(v_d[P][0]);
      end
      OpRotZ: begin
        ctl[2].pass = 1'b1;
        p3[0] = CW'(v_d[P][1]);
        p3[1] = -CW'(v_d[P][0]);
      end
      default: begin
        for (int k = 0; k < 3; k++) begin
          p1[k] = t_d[P][k];
          p3[k] = cr_d[P][k];
        end
      end
    endcase
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    vru_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk   (clk),
      .en    (en),
      .ctl   (ctl[k]),
      .p1    (p1[k]),
      .p2    (v_d[P][k]),
      .p3    (p3[k]),
      .cos_i (cos_w),
      .sin_i (sin_w),
      .res   (res[k]),
      .sat   (sat[k])
    );
  end

  // merge stage
  always_ff @(posedge clk) begin
    if (en) begin
      rx_r  <= res[0];
      ry_r  <= res[1];
      rz_r  <= res[2];
      sat_r <= sat[0] | sat[1] | sat[2];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rx        = rx_r;
  assign out_ry        = ry_r;
  assign out_rz        = rz_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valids moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[1])
    else $error("accepted transaction missing from pipeline");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_rx == 32'sh7fffffff || out_rx == 32'sh80000000 ||
       out_ry == 32'sh7fffffff || out_ry == 32'sh80000000 ||
       out_rz == 32'sh7fffffff || out_rz == 32'sh80000000))
    else $error("saturated flag without clipped component");
`endif

endmodule
`default_nettype wire

// ----- design/vru_cordic.sv -----
// Pipelined CORDIC: angle reduction, one stage per iteration, rounded cos/sin.
`default_nettype none
module vru_cordic
  import vru_pkg::*;
#(
  parameter int CORDIC_STEPS = CordicStepsDef,
  parameter int FRAC_BITS    = FracBitsDef
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [19:0]          angle,
  output logic signed [FRAC_BITS+2:0]      cos_o,
  output logic signed [FRAC_BITS+2:0]      sin_o
);

  localparam int Sh = AngFrac - FRAC_BITS;

  logic signed [ZW-1:0] z0, z1, z2, zf;
  logic                 negf;

  logic signed [ZW-1:0] z_r   [0:CORDIC_STEPS-1];
  logic signed [XW-1:0] x_r   [0:CORDIC_STEPS];
  logic signed [XW-1:0] y_r   [0:CORDIC_STEPS];
  logic                 neg_r [0:CORDIC_STEPS];

  logic signed [XW:0]   xf, yf, xh, yh;
  logic signed [FRAC_BITS+2:0] cos_r, sin_r;

  always_comb begin
    z0 = {{(ZW-34){angle[19]}}, angle, 14'b0};
    z1 = (z0 > PiQ30) ? z0 - TwoPiQ30 : z0;
    z2 = (z1 < -PiQ30) ? z1 + TwoPiQ30 : z1;
    negf = 1'b0;
    zf = z2;
    if (z2 > HalfPiQ30) begin
      zf = z2 - PiQ30;
      negf = 1'b1;
    end else if (z2 < -HalfPiQ30) begin
      zf = z2 + PiQ30;
      negf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r[0]   <= zf;
      x_r[0]   <= GainQ30;
      y_r[0]   <= '0;
      neg_r[0] <= negf;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        end
      end
      for (int i = 0; i < CORDIC_STEPS - 1; i++) begin
        z_r[i+1] <= (z_r[i] >= 0) ? z_r[i] - atan_q30(i) : z_r[i] + atan_q30(i);
      end
    end
  end

  always_comb begin
    xf = neg_r[CORDIC_STEPS] ? -(XW+1)'(x_r[CORDIC_STEPS]) : (XW+1)'(x_r[CORDIC_STEPS]);
    yf = neg_r[CORDIC_STEPS] ? -(XW+1)'(y_r[CORDIC_STEPS]) : (XW+1)'(y_r[CORDIC_STEPS]);
    xh = (xf + ((XW+1)'(1) <<< (Sh - 1))) >>> Sh;
    yh = (yf + ((XW+1)'(1) <<< (Sh - 1))) >>> Sh;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= xh[FRAC_BITS+2:0];
      sin_r <= yh[FRAC_BITS+2:0];
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

// ----- design/vru_lane.sv -----
// One output component lane: three products, sum, round and saturate, or pass p2 through.
`default_nettype none
module vru_lane
  import vru_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire lane_ctl_t                   ctl,
  input  wire logic signed [TW-1:0]        p1,
  input  wire logic signed [31:0]          p2,
  input  wire logic signed [CW-1:0]        p3,
  input  wire logic signed [FRAC_BITS+2:0] cos_i,
  input  wire logic signed [FRAC_BITS+2:0] sin_i,
  output logic signed [31:0]               res,
  output logic                             sat
);

  localparam int RW = FRAC_BITS + 41;
  localparam int OW = RW - FRAC_BITS;

  logic signed [FRAC_BITS+2:0]  omc;
  logic signed [TW+FRAC_BITS+2:0] m1_r;
  logic signed [32+FRAC_BITS+2:0] m2_r;
  logic signed [CW+FRAC_BITS+2:0] m3_r;
  logic signed [31:0]           p2_r;
  lane_ctl_t                    ctl_r;

  logic signed [RW-1:0] sum, sh;
  logic signed [OW-1:0] rv;
  logic signed [31:0]   res_r;
  logic                 sat_r;

  assign omc = ((FRAC_BITS+3)'(1) <<< FRAC_BITS) - cos_i;

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r  <= p1 * omc;
      m2_r  <= p2 * cos_i;
      m3_r  <= p3 * sin_i;
      p2_r  <= p2;
      ctl_r <= ctl;
    end
  end

  always_comb begin
    sum = RW'(m1_r) + RW'(m2_r) + RW'(m3_r);
    sh  = (sum + (RW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    rv  = sh[OW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (ctl_r.pass) begin
        res_r <= p2_r;
        sat_r <= 1'b0;
      end else if (rv > OW'(32'sh7fffffff)) begin
        res_r <= 32'sh7fffffff;
        sat_r <= 1'b1;
      end else if (rv < -OW'(33'sh080000000)) begin
        res_r <= 32'sh80000000;
        sat_r <= 1'b1;
      end else begin
        res_r <= rv[31:0];
        sat_r <= 1'b0;
      end
    end
  end

  assign res = res_r;
  assign sat = sat_r;

endmodule
`default_nettype wire
